// ===== rtl/pad_pkg.sv =====
// Package for the phased-array delay-law generator.
// Holds the state type, command and status structs, arithmetic constants and the sine table.
// No dependencies.
package pad_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_STEER_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ELEM  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_ELEM   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_STEP   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_APERTURE    = 4'd7;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_SECTOR = 2'd1;

  // divider operand widths
  localparam int NUM_W = 44;
  localparam int DEN_W = 34;
  localparam int CNT_W = 6;

  // steer = (75*k*S + 1664) / 3328, same as k*S*19200/851968 rounded half up.
  // 3328 = 256*13: drop 8 bits, then divide by 13 as (y * STEER_RECIP) >> RECIP_SH,
  // exact for y below 2^21.
  localparam logic [6:0]  STEER_MUL = 7'd75;
  localparam logic [30:0] STEER_RND = 31'd1664;
  localparam logic [21:0] STEER_RECIP = 22'd2581111;
  localparam int          RECIP_SH = 25;
  localparam logic [31:0] FOCUS_K   = 32'd2880000000;
  localparam logic [20:0] FOCUS_CAP = 21'd1048576;
  localparam logic signed [22:0] OFFSET16 = 23'sd8000;
  localparam logic signed [22:0] DELAY_MAX = 23'sd524287;
  localparam logic signed [22:0] DELAY_MIN = -23'sd524288;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_MUL1, ST_MUL2, ST_STEER, ST_DIV_F, ST_WAIT_F, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_beam;
    logic setup;
    logic mul1;
    logic mul2;
    logic div_start;
    logic lat_mag;
    logic lat_f;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic div_done;
    logic need_div;
    logic out_free;
    logic slot_last;
  } status_t;

  typedef logic [16:0] sin_tab_t [0:90];

  // Q16 sine of whole degrees, Q30 Taylor series to x^11; evaluated at elaboration
  function automatic sin_tab_t make_sin_tab();
    sin_tab_t tab;
    longint unsigned x, x2, t;
    longint sum;
    for (int deg = 0; deg <= 90; deg++) begin
      x = longint'(deg) * 64'd3373259426 / 64'd180;
      x2 = (x * x) >> 30;
      t = x;
      sum = longint'(x);
      for (int i = 1; i <= 5; i++) begin
        t = (t * x2) >> 30;
        case (i)
          1: t = t / 64'd6;
          2: t = t / 64'd20;
          3: t = t / 64'd42;
          4: t = t / 64'd72;
          default: t = t / 64'd110;
        endcase
        if (i % 2 == 1) sum = sum - longint'(t);
        else sum = sum + longint'(t);
      end
      if (sum <= 0) tab[deg] = 17'd0;
      else tab[deg] = 17'((longint'(sum) + 8192) >>> 14);
    end
    return tab;
  endfunction

  function automatic logic [19:0] sat20(input logic signed [22:0] v);
    logic signed [22:0] r;
    if (v > DELAY_MAX) r = DELAY_MAX;
    else if (v < DELAY_MIN) r = DELAY_MIN;
    else r = v;
    return r[19:0];
  endfunction

endpackage

// ===== rtl/pad_if.sv =====
// Channel interfaces of the delay-law generator: beam requests and element results.
// No dependencies.
interface pad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] beam_index;
  modport source (output valid, output beam_index, input ready);
  modport sink   (input valid, input beam_index, output ready);
endinterface

interface pad_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  slot_index;
  logic [10:0] element_id;
  logic [19:0] pulser_delay;
  logic [19:0] receiver_delay;
  logic        last_slot;
  logic        aperture_ended;
  modport source (output valid, output slot_index, output element_id, output pulser_delay,
                  output receiver_delay, output last_slot, output aperture_ended,
                  input ready);
  modport sink   (input valid, input slot_index, input element_id, input pulser_delay,
                  input receiver_delay, input last_slot, input aperture_ended,
                  output ready);
endinterface

// ===== rtl/pad_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on pad_pkg for operand widths.
module pad_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pad_pkg::NUM_W-1:0] num,
  input  logic [pad_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [pad_pkg::NUM_W-1:0] quo
);
  import pad_pkg::*;

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    ge = (trial >= {1'b0, den});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      cnt_nxt = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, den} : trial;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== rtl/pad_dp.sv =====
// Datapath: configuration registers, beam setup, per-slot delay arithmetic, output register.
// Depends on pad_pkg, pad_if and pad_div.
module pad_dp #(
  parameter int MAX_APERTURE = 64,
  parameter int ODD_SPLIT    = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pad_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                     beam_index,
  input  pad_pkg::cmd_t                  cmd,
  output pad_pkg::status_t               status,
  pad_out_if.source                      out_ch
);
  import pad_pkg::*;

  localparam sin_tab_t SIN_TAB = make_sin_tab();

  logic [1:0]        mode_r;
  logic signed [7:0] angle_r;
  logic [19:0]       focus_r;
  logic [13:0]       vel_r;
  logic [7:0]        first_r, lastel_r;
  logic [3:0]        step_r;
  logic [6:0]        size_r;

  logic [7:0]        beam_r;
  logic              halted_r;
  logic [6:0]        n_r, k_r;
  logic [5:0]        mid_r;
  logic [16:0]       s_r, mag_r;
  logic              neg_r, foc_r;
  logic [DEN_W-1:0]  den_r;
  logic [10:0]       id_r;
  logic [23:0]       prod_r;
  logic [11:0]       nn_r;
  logic [30:0]       snum_r;
  logic [NUM_W-1:0]  fnum_r;
  logic [20:0]       f_r;

  logic              out_valid_r;
  logic [5:0]        out_slot_r;
  logic [10:0]       out_id_r;
  logic [19:0]       out_pd_r, out_rd_r;
  logic              out_last_r, out_end_r;

  // slot count from configuration
  logic              foc;
  logic [6:0]        n_cap, n_w;
  logic [5:0]        mid_w;
  always_comb begin
    foc = (focus_r != 20'd0);
    n_cap = (size_r > 7'(MAX_APERTURE)) ? 7'(MAX_APERTURE) : size_r;
    n_w = n_cap;
    if (foc && !n_cap[0]) begin
      if (n_cap < 7'(ODD_SPLIT) && ({1'b0, n_cap} + 8'd1) <= 8'(MAX_APERTURE)) n_w = n_cap + 7'd1;
      else n_w = n_cap - 7'd1;
    end
    mid_w = (n_w > 7'd2) ? 6'((n_w - 7'd1) >> 1) : 6'd0;
  end

  // beam angle folded into the first quadrant
  logic signed [9:0] ang_sum, ang_w;
  logic [8:0]        ang_u;
  logic [6:0]        fold_w;
  logic              neg_w;
  logic [10:0]       id0_w;
  always_comb begin
    ang_sum = {{2{angle_r[7]}}, angle_r} +
              ((mode_r != MODE_LINEAR) ? $signed({2'b00, beam_r}) : 10'sd0);
    if (ang_sum < 10'sd0) ang_w = ang_sum + 10'sd360;
    else if (ang_sum >= 10'sd360) ang_w = ang_sum - 10'sd360;
    else ang_w = ang_sum;
    ang_u = ang_w[8:0];
    neg_w = 1'b0;
    if (ang_u <= 9'd90) fold_w = ang_u[6:0];
    else if (ang_u <= 9'd180) fold_w = 7'(9'd180 - ang_u);
    else if (ang_u <= 9'd270) begin
      fold_w = 7'(ang_u - 9'd180);
      neg_w = 1'b1;
    end else begin
      fold_w = 7'(9'd360 - ang_u);
      neg_w = 1'b1;
    end
    id0_w = {3'b000, first_r} + ((mode_r != MODE_SECTOR) ? {3'b000, beam_r} : 11'd0);
  end

  // per-slot terms
  logic [5:0]  nth_w;
  logic [10:0] next_w;
  logic        ended_w;
  always_comb begin
    nth_w = (k_r > {1'b0, mid_r}) ? 6'(k_r - {1'b0, mid_r}) : 6'({1'b0, mid_r} - k_r);
    next_w = id_r + {7'd0, step_r};
    ended_w = (next_w > {3'b000, lastel_r});
  end

  // steering magnitude: snum stays below 2^29, so bits 28:8 carry the dividend
  logic [42:0] recip_w;
  always_comb recip_w = 43'(snum_r[28:8]) * 43'(STEER_RECIP);

  logic              div_done;
  logic [NUM_W-1:0]  div_q;
  pad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (fnum_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_q)
  );

  logic signed [22:0] sm_w, d_w, rd_w;
  always_comb begin
    sm_w = neg_r ? -$signed({6'd0, mag_r}) : $signed({6'd0, mag_r});
    d_w  = sm_w - $signed({2'b00, f_r}) + OFFSET16;
    rd_w = d_w + OFFSET16;
  end

  // configuration and halt flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LINEAR;
      angle_r  <= '0;
      focus_r  <= '0;
      vel_r    <= 14'd5900;
      first_r  <= '0;
      lastel_r <= 8'd63;
      step_r   <= 4'd1;
      size_r   <= 7'd16;
      halted_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEER_MODE:  mode_r   <= cfg_data[1:0];
          REG_START_ANGLE: angle_r  <= cfg_data[7:0];
          REG_FOCUS:       focus_r  <= cfg_data[19:0];
          REG_VELOCITY:    vel_r    <= cfg_data[13:0];
          REG_FIRST_ELEM:  first_r  <= cfg_data[7:0];
          REG_LAST_ELEM:   lastel_r <= cfg_data[7:0];
          REG_ELEM_STEP:   step_r   <= cfg_data[3:0];
          REG_APERTURE:    size_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cmd.load_beam && beam_index == 8'd0) halted_r <= 1'b0;
      else if (cmd.emit && ended_w) halted_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_beam) beam_r <= beam_index;
    if (cmd.setup) begin
      n_r   <= n_w;
      mid_r <= mid_w;
      s_r   <= SIN_TAB[fold_w];
      neg_r <= neg_w;
      foc_r <= foc;
      den_r <= DEN_W'(focus_r) * DEN_W'(vel_r);
      id_r  <= id0_w;
      k_r   <= '0;
    end
    if (cmd.mul1) begin
      prod_r <= 24'(k_r) * 24'(s_r);
      nn_r   <= 12'(nth_w) * 12'(nth_w);
    end
    if (cmd.mul2) begin
      snum_r <= 31'(prod_r) * 31'(STEER_MUL) + STEER_RND;
      fnum_r <= NUM_W'(nn_r) * NUM_W'(FOCUS_K) + NUM_W'(den_r >> 1);
    end
    if (cmd.lat_mag) begin
      mag_r <= recip_w[RECIP_SH +: 17];
      f_r   <= foc_r ? FOCUS_CAP : 21'd0;
    end
    if (cmd.lat_f) f_r <= (div_q > NUM_W'(FOCUS_CAP)) ? FOCUS_CAP : div_q[20:0];
    if (cmd.emit) begin
      out_slot_r <= k_r[5:0];
      out_id_r   <= id_r;
      out_pd_r   <= sat20(d_w);
      out_rd_r   <= sat20(rd_w);
      out_last_r <= ended_w || (k_r + 7'd1 == n_r);
      out_end_r  <= ended_w;
      k_r        <= k_r + 7'd1;
      id_r       <= next_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_comb begin
    status.start_ok  = (beam_index == 8'd0 || !halted_r) && (n_w != 7'd0);
    status.div_done  = div_done;
    status.need_div  = foc_r && (den_r != '0);
    status.out_free  = !out_valid_r || out_ch.ready;
    status.slot_last = ended_w || (k_r + 7'd1 == n_r);
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.slot_index     = out_slot_r;
  assign out_ch.element_id     = out_id_r;
  assign out_ch.pulser_delay   = out_pd_r;
  assign out_ch.receiver_delay = out_rd_r;
  assign out_ch.last_slot      = out_last_r;
  assign out_ch.aperture_ended = out_end_r;
endmodule

// ===== rtl/pad_ctrl.sv =====
// Controller: sequences beam setup and per-slot multiply, divide and emit steps.
// Depends on pad_pkg.
module pad_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pad_pkg::status_t status,
  output pad_pkg::cmd_t    cmd
);
  import pad_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = status.start_ok ? ST_SETUP : ST_IDLE;
      ST_SETUP:  state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_STEER;
      ST_STEER:  state_nxt = status.need_div ? ST_DIV_F : ST_EMIT;
      ST_DIV_F:  state_nxt = ST_WAIT_F;
      ST_WAIT_F: if (status.div_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (status.out_free) state_nxt = status.slot_last ? ST_IDLE : ST_MUL1;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_beam = in_valid;
      end
      ST_SETUP:  cmd.setup = 1'b1;
      ST_MUL1:   cmd.mul1 = 1'b1;
      ST_MUL2:   cmd.mul2 = 1'b1;
      ST_STEER:  cmd.lat_mag = 1'b1;
      ST_DIV_F:  cmd.div_start = 1'b1;
      ST_WAIT_F: cmd.lat_f = status.div_done;
      ST_EMIT:   cmd.emit = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== rtl/phased_array_delay_law.sv =====
// Phased-array focal-law delay generator.
// Each beam request on in_ch produces one result per aperture slot on out_ch:
// slot, element id, pulser and receiver delay (signed, 1/16 unit, saturated),
// with last_slot on the final result and aperture_ended when the aperture ran
// past last_element. After that, requests other than beam 0 give no results.
// Configuration is to be written on cfg_we/cfg_index/cfg_data by the user only
// while the block is idle; the block itself does not enforce this. A request
// is taken only while no beam is in progress. After the transfer come setup,
// then per slot two multiply steps, the steering step, when focused the 44-step
// bit-serial divider for the focus term, and the emit step. The steering term
// uses a constant reciprocal multiply. A request yielding nothing is dropped.
// Results sit in an output register; when the receiver stalls, the block holds
// the next finished slot until that register is freed, and the request channel
// opens again once the last slot of the beam has been loaded.
// Reset (rst_n low, synchronous) restores register defaults, clears the halt
// and drops out_ch.valid.
module phased_array_delay_law #(
  parameter int MAX_APERTURE = 64,
  parameter int ODD_SPLIT    = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pad_in_if.sink                         in_ch,
  pad_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [pad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pad_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  pad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pad_dp #(
    .MAX_APERTURE (MAX_APERTURE),
    .ODD_SPLIT    (ODD_SPLIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .beam_index (in_ch.beam_index),
    .cmd        (cmd),
    .status     (status),
    .out_ch     (out_ch)
  );

  assign in_ch.ready = in_ready;
endmodule

// ===== rtl/pad_chk.sv =====
// Port-level checker for the delay-law generator, bound to the top level.
// Depends on pad_if signals reached through the bind connections.
module pad_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  slot_index,
  input logic [19:0] pulser_delay,
  input logic [19:0] receiver_delay,
  input logic        last_slot,
  input logic        aperture_ended
);
  logic       prev_last_r;
  logic [5:0] prev_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) prev_last_r <= 1'b1;
    else if (out_valid && out_ready) prev_last_r <= last_slot;
    if (out_valid && out_ready) prev_slot_r <= slot_index;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(pulser_delay))
    else $error("result changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && aperture_ended |-> last_slot)
    else $error("aperture_ended without last_slot");

  a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |->
      (prev_last_r ? slot_index == 6'd0 : slot_index == prev_slot_r + 6'd1))
    else $error("slot sequence broken");

  // both ends of the pulser range may hide a saturated sum
  a_rx_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pulser_delay != 20'h80000) &&
    ($signed(pulser_delay) <= 20'sd516287) |->
      $signed(receiver_delay) == $signed(pulser_delay) + 20'sd8000)
    else $error("receiver delay offset wrong");
endmodule

bind phased_array_delay_law pad_chk u_pad_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .slot_index     (out_ch.slot_index),
  .pulser_delay   (out_ch.pulser_delay),
  .receiver_delay (out_ch.receiver_delay),
  .last_slot      (out_ch.last_slot),
  .aperture_ended (out_ch.aperture_ended)
);
